/* sv/srd_pkg.sv */
// ----------------------------------------------------------------------------
// srd_pkg: shared types and codes for the scan record deframer
// Phase codes, result kinds, header size and the item/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

  // parser phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_KEYLEN = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_VALLEN = 3'd4;
  localparam logic [2:0] PH_VALUE  = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_HDR   = 3'd0;
  localparam logic [2:0] KIND_KEY   = 3'd1;
  localparam logic [2:0] KIND_VAL   = 3'd2;
  localparam logic [2:0] KIND_EMPTY = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // document header: flags 4, expiry 4, sequence 8, cas 8, datatype 1
  localparam logic [4:0] HDR_BYTES    = 5'd25;
  localparam logic [4:0] HDR_EXP_AT   = 5'd4;
  localparam logic [4:0] HDR_SEQ_AT   = 5'd8;
  localparam logic [4:0] HDR_CAS_AT   = 5'd16;
  localparam logic [4:0] HDR_DTYPE_AT = 5'd24;

  // last LEB128 byte index (fifth byte carries bits 31:28)
  localparam logic [2:0] LEB_LAST = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       payload_last;
    logic       keys_mode;
  } srd_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic        record_end;
    logic        payload_end;
    logic        error;
    logic [31:0] item_flags;
    logic [31:0] item_expiry;
    logic [63:0] item_sequence;
    logic [63:0] item_cas;
    logic [7:0]  item_datatype;
  } srd_result_t;

endpackage

`default_nettype wire

/* sv/srd_in_stage.sv */
// ----------------------------------------------------------------------------
// srd_in_stage: input register
// Holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic              consume,
  input  wire srd_pkg::srd_item_t item,
  output logic                   valid,
  output srd_pkg::srd_item_t     item_r
);
  import srd_pkg::*;

  logic valid_r, valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (consume) valid_nxt = 1'b0;
    if (load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  assign valid = valid_r;

endmodule

`default_nettype wire

/* sv/srd_core.sv */
// ----------------------------------------------------------------------------
// srd_core: record parser
// Phase machine, header capture, LEB128 length decode and byte counting.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire srd_pkg::srd_item_t item,
  output logic                    have,
  output srd_pkg::srd_result_t    res
);
  import srd_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  header_count_r, header_count_nxt;
  logic [31:0] flags_r, flags_nxt;
  logic [31:0] expiry_r, expiry_nxt;
  logic [63:0] sequence_r, sequence_nxt;
  logic [63:0] cas_r, cas_nxt;
  logic [7:0]  datatype_r, datatype_nxt;
  logic [31:0] length_accum_r, length_accum_nxt;
  logic [2:0]  length_shift_r, length_shift_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic        error_seen_r, error_seen_nxt;

  logic [7:0]  b;
  logic        last, km;
  logic        fail, hdr, rend, err, leb_done;
  logic [2:0]  kind;
  logic [7:0]  ob;
  logic [4:0]  cnt;

  assign b    = item.data_byte;
  assign last = item.payload_last;
  assign km   = item.keys_mode;

  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    flags_nxt        = flags_r;
    expiry_nxt       = expiry_r;
    sequence_nxt     = sequence_r;
    cas_nxt          = cas_r;
    datatype_nxt     = datatype_r;
    length_accum_nxt = length_accum_r;
    length_shift_nxt = length_shift_r;
    bytes_left_nxt   = bytes_left_r;
    error_seen_nxt   = error_seen_r;
    have     = 1'b0;
    fail     = 1'b0;
    hdr      = 1'b0;
    rend     = 1'b0;
    err      = 1'b0;
    leb_done = 1'b0;
    kind     = KIND_HDR;
    ob       = 8'd0;
    cnt      = header_count_r + 5'd1;

    if (step && error_seen_r) begin
      // drop the rest of a payload after a bad length
      if (last) begin
        error_seen_nxt   = 1'b0;
        phase_nxt        = PH_IDLE;
        length_accum_nxt = '0;
        length_shift_nxt = '0;
        header_count_nxt = '0;
      end
    end else if (step) begin
      if (phase_nxt > PH_VALUE) phase_nxt = PH_IDLE;
      if (phase_nxt == PH_IDLE) begin
        if (km) begin
          phase_nxt        = PH_KEYLEN;
          length_accum_nxt = '0;
          length_shift_nxt = '0;
        end else begin
          phase_nxt        = PH_HEADER;
          header_count_nxt = '0;
        end
      end
      cnt = header_count_nxt + 5'd1;

      case (phase_nxt)
        PH_HEADER: begin
          if (header_count_nxt < HDR_EXP_AT) flags_nxt = {flags_r[23:0], b};
          else if (header_count_nxt < HDR_SEQ_AT) expiry_nxt = {expiry_r[23:0], b};
          else if (header_count_nxt < HDR_CAS_AT) sequence_nxt = {sequence_r[55:0], b};
          else if (header_count_nxt < HDR_DTYPE_AT) cas_nxt = {cas_r[55:0], b};
          else datatype_nxt = b;
          if (cnt >= HDR_BYTES) begin
            have             = 1'b1;
            hdr              = 1'b1;
            kind             = KIND_HDR;
            header_count_nxt = '0;
            phase_nxt        = PH_KEYLEN;
            length_accum_nxt = '0;
            length_shift_nxt = '0;
          end else begin
            header_count_nxt = cnt;
          end
        end
        PH_KEYLEN, PH_VALLEN: begin
          if (length_shift_nxt >= LEB_LAST) begin
            if (b[7:4] != 4'd0) begin
              fail = 1'b1;
            end else begin
              length_accum_nxt = length_accum_nxt | {b[3:0], 28'd0};
              length_shift_nxt = '0;
              leb_done         = 1'b1;
            end
          end else begin
            case (length_shift_nxt[1:0])
              2'd0:    length_accum_nxt = length_accum_nxt | {25'd0, b[6:0]};
              2'd1:    length_accum_nxt = length_accum_nxt | {18'd0, b[6:0], 7'd0};
              2'd2:    length_accum_nxt = length_accum_nxt | {11'd0, b[6:0], 14'd0};
              default: length_accum_nxt = length_accum_nxt | {4'd0, b[6:0], 21'd0};
            endcase
            if (b[7]) begin
              length_shift_nxt = length_shift_nxt + 3'd1;
            end else begin
              length_shift_nxt = '0;
              leb_done         = 1'b1;
            end
          end
          if (leb_done) begin
            if (length_accum_nxt != 32'd0) begin
              bytes_left_nxt = length_accum_nxt;
              phase_nxt      = (phase_nxt == PH_KEYLEN) ? PH_KEY : PH_VALUE;
            end else if (phase_nxt == PH_KEYLEN && !km) begin
              // empty key in a document: value length follows
              phase_nxt        = PH_VALLEN;
              length_accum_nxt = '0;
              length_shift_nxt = '0;
            end else begin
              have      = 1'b1;
              kind      = KIND_EMPTY;
              rend      = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_KEY, PH_VALUE: begin
          have = 1'b1;
          kind = (phase_nxt == PH_KEY) ? KIND_KEY : KIND_VAL;
          ob   = b;
          if (bytes_left_nxt != 32'd0) bytes_left_nxt = bytes_left_nxt - 32'd1;
          if (bytes_left_nxt == 32'd0) begin
            if (phase_nxt == PH_VALUE || km) begin
              rend      = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt        = PH_VALLEN;
              length_accum_nxt = '0;
              length_shift_nxt = '0;
            end
          end
        end
        default: begin
        end
      endcase

      if (fail) begin
        have             = 1'b1;
        kind             = KIND_ERR;
        err              = 1'b1;
        rend             = 1'b0;
        hdr              = 1'b0;
        ob               = 8'd0;
        phase_nxt        = PH_IDLE;
        length_accum_nxt = '0;
        length_shift_nxt = '0;
        if (!last) error_seen_nxt = 1'b1;
      end else if (last && phase_nxt != PH_IDLE) begin
        // record cut short by payload end
        err = 1'b1;
        if (!have) begin
          have = 1'b1;
          kind = KIND_ERR;
        end
      end
      if (last) begin
        phase_nxt        = PH_IDLE;
        header_count_nxt = '0;
        length_accum_nxt = '0;
        length_shift_nxt = '0;
        bytes_left_nxt   = '0;
      end
    end
  end

  always_comb begin
    res               = '0;
    res.kind          = kind;
    res.out_byte      = ob;
    res.record_end    = rend;
    res.payload_end   = last;
    res.error         = err;
    if (hdr) begin
      res.item_flags    = flags_nxt;
      res.item_expiry   = expiry_nxt;
      res.item_sequence = sequence_nxt;
      res.item_cas      = cas_nxt;
      res.item_datatype = datatype_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      header_count_r <= '0;
      length_accum_r <= '0;
      length_shift_r <= '0;
      bytes_left_r   <= '0;
      error_seen_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      length_accum_r <= length_accum_nxt;
      length_shift_r <= length_shift_nxt;
      bytes_left_r   <= bytes_left_nxt;
      error_seen_r   <= error_seen_nxt;
    end
  end

  // header fields are fully overwritten before they are ever shown
  always_ff @(posedge clk) begin
    flags_r    <= flags_nxt;
    expiry_r   <= expiry_nxt;
    sequence_r <= sequence_nxt;
    cas_r      <= cas_nxt;
    datatype_r <= datatype_nxt;
  end

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    header_count_r < HDR_BYTES)
    else $error("header byte count out of range");

  a_leb_shift: assert property (@(posedge clk) disable iff (!rst_n)
    length_shift_r <= LEB_LAST)
    else $error("LEB128 byte index out of range");

  a_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KEY || phase_r == PH_VALUE) |-> bytes_left_r != 32'd0)
    else $error("data phase with no bytes left");

  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    error_seen_r |-> phase_r == PH_IDLE)
    else $error("dropping payload while a record is open");

  a_error_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (step && have && kind == KIND_ERR) |-> err)
    else $error("error-only result without error flag");

endmodule

`default_nettype wire

/* sv/srd_out_stage.sv */
// ----------------------------------------------------------------------------
// srd_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire srd_pkg::srd_result_t res,
  input  wire logic                 ready,
  output logic                      valid,
  output srd_pkg::srd_result_t      res_r
);
  import srd_pkg::*;

  logic valid_r, valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (ready) valid_nxt = 1'b0;
    if (load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign valid = valid_r;

endmodule

`default_nettype wire

/* sv/scan_record_deframer.sv */
// ----------------------------------------------------------------------------
// scan_record_deframer: scan payload record splitter
// Splits a byte stream into key-only or document records (header, key,
// value), forwarding key/value bytes and the decoded 25-byte header.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                      | tlast        | tuser
//  --------+-----+----------------------------+--------------+------------------
//  in_     | in  | data_byte                  | payload_last | keys_mode
//  out_    | out | out_byte, payload_end, hdr | record_end   | kind, error
//
//  One byte per cycle sustained while out_tready is high; a byte gives zero or
//  one result transaction, via input register, then parser plus result register.
//  The parser steps whenever its input register is full and the result
//  register is empty or being drained, so in_tready follows out_tready.
//  rst_n (synchronous) returns the parser to idle and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_record_deframer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tlast,   // payload_last
  input  wire logic         in_tuser,   // keys_mode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [215:0]      out_tdata,  // [7:0] out_byte, [8] payload_end,
                                        // [40:9] item_flags, [72:41] item_expiry,
                                        // [136:73] item_sequence,
                                        // [200:137] item_cas,
                                        // [208:201] item_datatype, rest zero
  output logic              out_tlast,  // record_end
  output logic [3:0]        out_tuser   // [2:0] kind, [3] error
);
  import srd_pkg::*;

  srd_item_t   in_item, item_q;
  srd_result_t res, res_q;
  logic        in_load, item_valid, step, have;

  assign in_item.data_byte    = in_tdata;
  assign in_item.payload_last = in_tlast;
  assign in_item.keys_mode    = in_tuser;

  // parser advances when the result slot can take whatever it produces
  assign step      = item_valid && (!out_tvalid || out_tready);
  assign in_tready = !item_valid || step;
  assign in_load   = in_tvalid && in_tready;

  srd_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_load),
    .consume (step),
    .item    (in_item),
    .valid   (item_valid),
    .item_r  (item_q)
  );

  srd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_q),
    .have  (have),
    .res   (res)
  );

  srd_out_stage u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (step && have),
    .res   (res),
    .ready (out_tready),
    .valid (out_tvalid),
    .res_r (res_q)
  );

  assign out_tdata = {7'd0, res_q.item_datatype, res_q.item_cas, res_q.item_sequence,
                      res_q.item_expiry, res_q.item_flags, res_q.payload_end,
                      res_q.out_byte};
  assign out_tlast = res_q.record_end;
  assign out_tuser = {res_q.error, res_q.kind};

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for scan_record_deframer
// Drives scan payloads (keys-only and document records, truncated payloads,
// bad LEB128 lengths, mode switches, random noise) one byte per transaction,
// predicts every result with a bit-accurate software deframer and compares
// each output transaction field by field. Both sides idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  import srd_pkg::*;

  // LEB128 decoder step outcome
  localparam logic [1:0] LEB_MORE = 2'd0;
  localparam logic [1:0] LEB_DONE = 2'd1;
  localparam logic [1:0] LEB_BAD  = 2'd2;

  localparam int RANDOM_BYTES = 500;
  localparam int NO_SWITCH    = 1 << 30;  // mode switch index that is never reached

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic [7:0]   in_tdata   = 8'h00;
  logic         in_tlast   = 1'b0;
  logic         in_tuser   = 1'b0;
  logic         out_tready = 1'b0;
  logic         in_tready;
  logic         out_tvalid;
  logic [215:0] out_tdata;
  logic         out_tlast;
  logic [3:0]   out_tuser;

  scan_record_deframer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] data_byte
    .in_tlast   (in_tlast),    // payload_last
    .in_tuser   (in_tuser),    // keys_mode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte, [8] payload_end, [40:9] flags,
                               // [72:41] expiry, [136:73] sequence,
                               // [200:137] cas, [208:201] datatype
    .out_tlast  (out_tlast),   // record_end
    .out_tuser  (out_tuser)    // [2:0] kind, [3] error
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Software deframer: mirrors the parser state and predicts one result per
  // accepted byte (or none).
  // --------------------------------------------------------------------------
  logic [2:0]  cur_phase;
  logic [4:0]  hdr_count;
  logic [31:0] hdr_flags;
  logic [31:0] hdr_expiry;
  logic [63:0] hdr_seq;
  logic [63:0] hdr_cas;
  logic [7:0]  hdr_dtype;
  logic [31:0] leb_value;
  logic [2:0]  leb_count;
  logic [31:0] bytes_to_go;
  bit          skip_payload;   // set after a bad length until the payload ends

  srd_result_t pending_results[$];
  logic [7:0]  pay_q[$];       // payload under construction
  int          n_sent;
  int          n_fail;
  bit          quiet;          // no idling on either side while set

  function automatic void deframe_reset();
    cur_phase    = PH_IDLE;
    hdr_count    = '0;
    hdr_flags    = '0;
    hdr_expiry   = '0;
    hdr_seq      = '0;
    hdr_cas      = '0;
    hdr_dtype    = '0;
    leb_value    = '0;
    leb_count    = '0;
    bytes_to_go  = '0;
    skip_payload = 1'b0;
  endfunction

  function automatic void leb_clear();
    leb_value = '0;
    leb_count = '0;
  endfunction

  // Fifth byte may only carry bits 31:28 and must end the length.
  function automatic logic [1:0] leb_take(input logic [7:0] b);
    if (leb_count >= LEB_LAST) begin
      if (b[7] || b[6:4] != 3'd0) return LEB_BAD;
      leb_value = leb_value | {b[3:0], 28'd0};
      leb_count = '0;
      return LEB_DONE;
    end
    leb_value = leb_value | (32'(b[6:0]) << (7 * leb_count));
    if (b[7]) begin
      leb_count = leb_count + 3'd1;
      return LEB_MORE;
    end
    leb_count = '0;
    return LEB_DONE;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic last,
                                       input logic km, output bit have,
                                       output srd_result_t r);
    bit         fail;
    bit         hdr;
    bit         rend;
    bit         err;
    logic [2:0] kind;
    logic [7:0] ob;
    logic [4:0] c;
    logic [1:0] lr;
    have = 1'b0;
    fail = 1'b0;
    hdr  = 1'b0;
    rend = 1'b0;
    err  = 1'b0;
    kind = KIND_HDR;
    ob   = 8'h00;
    r    = '0;
    // after a bad length everything up to the payload end is dropped
    if (skip_payload) begin
      if (last) begin
        skip_payload = 1'b0;
        cur_phase    = PH_IDLE;
        hdr_count    = '0;
        leb_clear();
      end
      return;
    end
    if (cur_phase == PH_IDLE) begin
      if (km) begin
        cur_phase = PH_KEYLEN;
        leb_clear();
      end else begin
        cur_phase = PH_HEADER;
        hdr_count = '0;
      end
    end
    case (cur_phase)
      PH_HEADER: begin
        c = hdr_count;
        if (c < HDR_EXP_AT) hdr_flags = {hdr_flags[23:0], b};
        else if (c < HDR_SEQ_AT) hdr_expiry = {hdr_expiry[23:0], b};
        else if (c < HDR_CAS_AT) hdr_seq = {hdr_seq[55:0], b};
        else if (c < HDR_DTYPE_AT) hdr_cas = {hdr_cas[55:0], b};
        else hdr_dtype = b;
        c = c + 5'd1;
        if (c >= HDR_BYTES) begin
          have      = 1'b1;
          hdr       = 1'b1;
          kind      = KIND_HDR;
          hdr_count = '0;
          cur_phase = PH_KEYLEN;
          leb_clear();
        end else begin
          hdr_count = c;
        end
      end
      PH_KEYLEN, PH_VALLEN: begin
        lr = leb_take(b);
        if (lr == LEB_BAD) begin
          fail = 1'b1;
        end else if (lr == LEB_DONE) begin
          if (cur_phase == PH_KEYLEN) begin
            if (leb_value != 32'd0) begin
              bytes_to_go = leb_value;
              cur_phase   = PH_KEY;
            end else if (km) begin
              have      = 1'b1;
              kind      = KIND_EMPTY;
              rend      = 1'b1;
              cur_phase = PH_IDLE;
            end else begin
              // empty key in a document: value length follows
              cur_phase = PH_VALLEN;
              leb_clear();
            end
          end else if (leb_value != 32'd0) begin
            bytes_to_go = leb_value;
            cur_phase   = PH_VALUE;
          end else begin
            have      = 1'b1;
            kind      = KIND_EMPTY;
            rend      = 1'b1;
            cur_phase = PH_IDLE;
          end
        end
      end
      PH_KEY, PH_VALUE: begin
        have = 1'b1;
        kind = (cur_phase == PH_KEY) ? KIND_KEY : KIND_VAL;
        ob   = b;
        if (bytes_to_go != 32'd0) bytes_to_go = bytes_to_go - 32'd1;
        if (bytes_to_go == 32'd0) begin
          // the current byte's mode decides whether a finished key ends it
          if (cur_phase == PH_VALUE || km) begin
            rend      = 1'b1;
            cur_phase = PH_IDLE;
          end else begin
            cur_phase = PH_VALLEN;
            leb_clear();
          end
        end
      end
      default: ;
    endcase
    if (fail) begin
      have      = 1'b1;
      kind      = KIND_ERR;
      err       = 1'b1;
      rend      = 1'b0;
      hdr       = 1'b0;
      ob        = 8'h00;
      cur_phase = PH_IDLE;
      leb_clear();
      if (!last) skip_payload = 1'b1;
    end else if (last && cur_phase != PH_IDLE) begin
      // payload ended inside a record
      err = 1'b1;
      if (!have) begin
        have = 1'b1;
        kind = KIND_ERR;
      end
      cur_phase = PH_IDLE;
    end
    if (last) begin
      cur_phase   = PH_IDLE;
      hdr_count   = '0;
      bytes_to_go = '0;
      leb_clear();
    end
    r.kind        = kind;
    r.out_byte    = ob;
    r.record_end  = rend;
    r.payload_end = last;
    r.error       = err;
    if (hdr) begin
      r.item_flags    = hdr_flags;
      r.item_expiry   = hdr_expiry;
      r.item_sequence = hdr_seq;
      r.item_cas      = hdr_cas;
      r.item_datatype = hdr_dtype;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Payload builders
  // --------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] b);
    pay_q.push_back(b);
  endfunction

  function automatic void add_bytes(input int n);
    for (int i = 0; i < n; i++) pay_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_leb(input int unsigned len);
    logic [7:0] b;
    do begin
      b   = {1'b0, len[6:0]};
      len = len >> 7;
      if (len != 0) b[7] = 1'b1;
      pay_q.push_back(b);
    end while (len != 0);
  endfunction

  function automatic void add_header_fill(input logic [7:0] b);
    for (int i = 0; i < int'(HDR_BYTES); i++) pay_q.push_back(b);
  endfunction

  function automatic void add_key_record(input int unsigned klen);
    add_leb(klen);
    add_bytes(klen);
  endfunction

  function automatic void add_doc_record(input int unsigned klen, input int unsigned vlen);
    add_bytes(int'(HDR_BYTES));
    add_key_record(klen);
    add_key_record(vlen);
  endfunction

  // mostly short records, now and then one that needs a two-byte length
  function automatic int unsigned rand_len();
    int s;
    s = $urandom_range(0, 9);
    if (s < 6) return $urandom_range(0, 4);
    if (s < 9) return $urandom_range(5, 20);
    return $urandom_range(120, 140);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one byte per transaction, random gap before each
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] d, input logic last, input logic km);
    int          gap;
    bit          have;
    srd_result_t r;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    in_tuser  <= km;
    do @(posedge clk); while (!in_tready);
    deframe_byte(d, last, km, have, r);
    if (have) pending_results.push_back(r);
    n_sent++;
  endtask

  // Sends pay_q as one payload; bytes from switch_at on carry the other mode.
  task automatic send_payload(input logic km, input int switch_at);
    for (int i = 0; i < pay_q.size(); i++)
      send_byte(pay_q[i], i == pay_q.size() - 1, (i >= switch_at) ? !km : km);
    pay_q.delete();
  endtask

  // Always waits on the clock first, so valid never drops and rises in one step.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall per result, then compare with the oldest
  // prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    end
  endtask

  task automatic check_result();
    srd_result_t want;
    if (pending_results.size() == 0) begin
      n_fail++;
      $display("%0t: unexpected result transaction: expected none, actual tdata %h tuser %h",
               $time, out_tdata, out_tuser);
      return;
    end
    want = pending_results.pop_front();
    check_field("kind",        64'(want.kind),          64'(out_tuser[2:0]));
    check_field("error",       64'(want.error),         64'(out_tuser[3]));
    check_field("record_end",  64'(want.record_end),    64'(out_tlast));
    check_field("out_byte",    64'(want.out_byte),      64'(out_tdata[7:0]));
    check_field("payload_end", 64'(want.payload_end),   64'(out_tdata[8]));
    check_field("flags",       64'(want.item_flags),    64'(out_tdata[40:9]));
    check_field("expiry",      64'(want.item_expiry),   64'(out_tdata[72:41]));
    check_field("sequence",    want.item_sequence,      out_tdata[136:73]);
    check_field("cas",         want.item_cas,           out_tdata[200:137]);
    check_field("datatype",    64'(want.item_datatype), 64'(out_tdata[208:201]));
    check_field("tdata pad",   64'd0,                   64'(out_tdata[215:209]));
  endtask

  initial begin : result_sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result();
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // keys mode: empty record, one-byte key of zero, two-byte key with 0xFF
  task automatic test_keys_records();
    add_leb(0);
    add_leb(1);
    add_byte(8'h00);
    add_leb(2);
    add_byte(8'hFF);
    add_byte(8'h5A);
    send_payload(1'b1, NO_SWITCH);
  endtask

  // document mode: all-ones header, all-zeros header with empty key and
  // empty value, then empty key with a real value
  task automatic test_doc_records();
    add_header_fill(8'hFF);
    add_leb(1);
    add_byte(8'h00);
    add_leb(1);
    add_byte(8'hFF);
    add_header_fill(8'h00);
    add_leb(0);
    add_leb(0);
    add_bytes(int'(HDR_BYTES));
    add_leb(0);
    add_key_record(2);
    send_payload(1'b0, NO_SWITCH);
  endtask

  // payload ends inside a key, a length and a header, and just before a value length
  task automatic test_truncation();
    add_leb(3);
    add_bytes(1);
    send_payload(1'b1, NO_SWITCH);
    add_byte(8'h85);
    send_payload(1'b1, NO_SWITCH);
    add_bytes(10);
    send_payload(1'b0, NO_SWITCH);
    add_bytes(int'(HDR_BYTES));
    add_key_record(1);
    send_payload(1'b0, NO_SWITCH);
  endtask

  // bad LEB128 lengths: continuation on the fifth byte, overflow on the
  // payload's last byte, a legal five-byte zero length, then a bad key length after a header
  task automatic test_bad_length();
    repeat (5) add_byte(8'h80);
    add_bytes(3);
    send_payload(1'b1, NO_SWITCH);
    repeat (4) add_byte(8'hFF);
    add_byte(8'h10);
    send_payload(1'b1, NO_SWITCH);
    repeat (4) add_byte(8'h80);
    add_byte(8'h00);
    send_payload(1'b1, NO_SWITCH);
    add_bytes(int'(HDR_BYTES));
    repeat (4) add_byte(8'hFF);
    add_byte(8'hFF);
    add_bytes(2);
    send_payload(1'b0, NO_SWITCH);
  endtask

  // mode flips on the last key byte: document key ends the record, keys-mode
  // key falls through to a value
  task automatic test_mode_switch();
    add_bytes(int'(HDR_BYTES));
    add_key_record(2);
    add_key_record(1);
    send_payload(1'b0, int'(HDR_BYTES) + 2);
    add_key_record(2);
    add_key_record(3);
    send_payload(1'b1, 2);
  endtask

  task automatic test_random_payloads();
    int   start;
    int   sel;
    int   n;
    int   cut;
    logic km;
    start = n_sent;
    while (n_sent - start < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 4) == 0);
      km    = 1'($urandom_range(0, 1));
      sel   = $urandom_range(0, 9);
      if (sel < 6) begin
        // well-formed payload of a few records
        n = $urandom_range(1, 3);
        repeat (n) begin
          if (km) add_key_record(rand_len());
          else add_doc_record(rand_len(), rand_len());
        end
        send_payload(km, NO_SWITCH);
      end else if (sel < 8) begin
        // one record cut short at a random point
        if (km) add_key_record(rand_len());
        else add_doc_record(rand_len(), rand_len());
        cut = $urandom_range(1, pay_q.size());
        while (pay_q.size() > cut) void'(pay_q.pop_back());
        send_payload(km, NO_SWITCH);
      end else if (sel == 8) begin
        // noise, possibly flipping mode part way
        n = $urandom_range(1, 24);
        add_bytes(n);
        send_payload(km, $urandom_range(0, n));
      end else begin
        // overlong length, sometimes after a header, with trailing junk
        if (!km) add_bytes(int'(HDR_BYTES));
        repeat (4) add_byte(8'($urandom_range(128, 255)));
        add_byte(8'($urandom_range(16, 255)));
        add_bytes($urandom_range(0, 5));
        send_payload(km, NO_SWITCH);
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    n_sent = 0;
    n_fail = 0;
    quiet  = 1'b0;
    deframe_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_keys_records();
    test_doc_records();
    test_truncation();
    // let everything drain before the error cases
    wait_drained();
    test_bad_length();
    test_mode_switch();
    test_random_payloads();
    wait_drained();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
